// ===== rtl/bwma_pkg.sv =====
package bwma_pkg;

  localparam int REG_LEVELS      = 5;
  localparam int LEVELS_DEF      = 5;
  localparam int SIZE_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int SIZE_REG_BITS   = 16;
  localparam int MASK_BITS       = 4 * REG_LEVELS;
  localparam int MODE_BITS       = 3;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 20;
  localparam logic [31:0] QNAN   = 32'h7FC0_0000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SIZE0 = 3'd0,
    REG_SIZE1 = 3'd1,
    REG_SIZE2 = 3'd2,
    REG_SIZE3 = 3'd3,
    REG_SIZE4 = 3'd4,
    REG_MASKS = 3'd5,
    REG_MODE  = 3'd6
  } cfg_reg_e;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD     = 3'd0,
    MODE_SUB     = 3'd1,
    MODE_RSUB    = 3'd2,
    MODE_DOT_ADD = 3'd3,
    MODE_DOT_SUB = 3'd4
  } op_mode_e;

  typedef struct packed {
    logic [31:0] a_value;
    logic [31:0] b_value;
    logic [31:0] c_value;
    logic [31:0] d_value;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [31:0] out_index;
    logic [31:0] next_a_offset;
    logic [31:0] next_b_offset;
    logic [31:0] next_c_offset;
    logic [31:0] next_d_offset;
    logic        final_element;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic [REG_LEVELS-1:0][SIZE_REG_BITS-1:0] sizes;
    logic [MASK_BITS-1:0]                     masks;
    logic [MODE_BITS-1:0]                     mode;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] bits;
  } spec_t;

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd0;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!hit) begin
        if (v[i]) hit = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [23:0] mant24(input logic [31:0] x);
    return {|x[30:23], x[22:0]};
  endfunction

  function automatic spec_t mul_special(input logic [31:0] x, input logic [31:0] y);
    logic  xn, yn, xi, yi, xz, yz, s;
    spec_t r;
    xn = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    yn = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    xi = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    yi = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    xz = (x[30:0] == 31'd0);
    yz = (y[30:0] == 31'd0);
    s  = x[31] ^ y[31];
    r  = '{valid: 1'b0, bits: 32'd0};
    if (xn || yn || (xi && yz) || (xz && yi)) r = '{valid: 1'b1, bits: QNAN};
    else if (xi || yi) r = '{valid: 1'b1, bits: {s, 8'hFF, 23'd0}};
    else if (xz || yz) r = '{valid: 1'b1, bits: {s, 31'd0}};
    return r;
  endfunction

  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [9:0] e,
                                             input logic [26:0] sig);
    logic [26:0]        m;
    logic [26:0]        lost;
    logic [9:0]         sh;
    logic               up;
    logic [24:0]        r;
    logic signed [9:0]  ee;
    logic [22:0]        frac;
    m    = sig;
    lost = '0;
    ee   = e;
    sh   = 10'd0;
    if (e <= 10'sd0) begin
      sh = 10'(10'sd1 - e);
      if (sh >= 10'd27) begin
        lost = sig;
        m    = '0;
      end else begin
        lost = sig & ((27'd1 << sh) - 27'd1);
        m    = sig >> sh;
      end
    end
    m[0] = m[0] | (|lost);
    up   = m[2] & (m[3] | m[1] | m[0]);
    r    = {1'b0, m[26:3]} + {24'd0, up};
    if (e > 10'sd0) begin
      if (r[24]) begin
        ee   = e + 10'sd1;
        frac = r[23:1];
      end else begin
        frac = r[22:0];
      end
      if (ee >= 10'sd255) return {sgn, 8'hFF, 23'd0};
      return {sgn, ee[7:0], frac};
    end
    return {sgn, 7'd0, r[23], r[22:0]};
  endfunction

endpackage

// ===== rtl/bwma_in_if.sv =====
interface bwma_in_if;
  import bwma_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bwma_out_if.sv =====
interface bwma_out_if;
  import bwma_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bwma_cfg_if.sv =====
interface bwma_cfg_if;
  import bwma_pkg::*;
  logic      valid;
  logic      ready;
  cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bwma_queue.sv =====
module bwma_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop) rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop)) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("pop from empty queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CW'(1))) else $error("queue count step");

endmodule

// ===== rtl/bwma_front.sv =====
module bwma_front #(
  parameter int LEVELS    = 5,
  parameter int SIZE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bwma_cfg_if.sink                          cfg_s,
  bwma_in_if.sink                           in_s,
  input  logic                              q_full,
  output logic                              q_push,
  output bwma_pkg::in_beat_t                q_item,
  output logic [LEVELS-1:0][SIZE_BITS-1:0]  q_cnt,
  output logic [31:0]                       q_index,
  output logic                              q_final,
  output bwma_pkg::cfg_t                    cfg_o
);
  import bwma_pkg::*;

  logic [REG_LEVELS-1:0][SIZE_REG_BITS-1:0] size_r;
  logic [MASK_BITS-1:0]                     masks_r;
  logic [MODE_BITS-1:0]                     mode_r;
  logic [LEVELS-1:0][SIZE_BITS-1:0]         cnt_r, cnt_nxt, esz;
  logic [31:0]                              pos_r;
  logic                                     carry;

  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_REG_BITS-1:0] v);
    logic [SIZE_BITS-1:0] t;
    t = SIZE_BITS'(v);
    return (t == '0) ? SIZE_BITS'(1) : t;
  endfunction

  assign cfg_s.ready = 1'b1;
  assign cfg_o       = '{sizes: size_r, masks: masks_r, mode: mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_LEVELS; i++) size_r[i] <= SIZE_REG_BITS'(1);
      masks_r <= '0;
      mode_r  <= '0;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.data.index) inside
        REG_SIZE0, REG_SIZE1, REG_SIZE2, REG_SIZE3, REG_SIZE4:
          size_r[cfg_s.data.index] <= cfg_s.data.value[SIZE_REG_BITS-1:0];
        REG_MASKS: masks_r <= cfg_s.data.value[MASK_BITS-1:0];
        REG_MODE:  mode_r  <= cfg_s.data.value[MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < LEVELS; g++) begin : g_esz
    if (g < REG_LEVELS) begin : g_reg
      assign esz[g] = eff_size(size_r[g]);
    end else begin : g_one
      assign esz[g] = SIZE_BITS'(1);
    end
  end

  always_comb begin
    carry   = 1'b1;
    cnt_nxt = cnt_r;
    for (int l = 0; l < LEVELS; l++) begin
      if (carry) begin
        if (cnt_r[l] >= esz[l] - SIZE_BITS'(1)) begin
          cnt_nxt[l] = '0;
        end else begin
          cnt_nxt[l] = cnt_r[l] + SIZE_BITS'(1);
          carry      = 1'b0;
        end
      end
    end
  end

  assign in_s.ready = !q_full;
  assign q_push     = in_s.valid && !q_full;
  assign q_item     = in_s.data;
  assign q_cnt      = cnt_nxt;
  assign q_index    = pos_r;
  assign q_final    = carry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else if (q_push) begin
      cnt_r <= cnt_nxt;
      pos_r <= carry ? 32'd0 : pos_r + 32'd1;
    end
  end

endmodule

// ===== rtl/bwma_back.sv =====
module bwma_back #(
  parameter int LEVELS      = 5,
  parameter int SIZE_BITS   = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bwma_pkg::cfg_t                    cfg,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  bwma_pkg::in_beat_t                h_item,
  input  logic [LEVELS-1:0][SIZE_BITS-1:0]  h_cnt,
  input  logic [31:0]                       h_index,
  input  logic                              h_final,
  bwma_out_if.source                        out_s
);
  import bwma_pkg::*;

  localparam int NST = 9;
  localparam int OB  = OFFSET_BITS;

  logic           adv;
  logic [NST-1:0] v_r;

  // offset walk, one level per stage
  logic [LEVELS-1:0][SIZE_BITS-1:0] oc_r  [NST];
  logic [3:0][OB-1:0]               off_r [NST];
  logic [3:0][OB-1:0]               scl_r [NST];
  logic [31:0]                      ix_r  [NST];
  logic                             fn_r  [NST];

  // float datapath
  logic [3:0][31:0]        x0_r;
  logic [3:0][4:0]         lz0_r;
  spec_t                   sp1_0_r, sp2_0_r;
  logic [3:0][23:0]        m1_r;
  logic [3:0][9:0]         e1_r;
  logic [31:0]             c1_r, c2_r, c3_r;
  logic                    s1a_r, s1b_r, s2a_r, s2b_r;
  spec_t                   sp1_1_r, sp2_1_r, sp1_2_r, sp2_2_r;
  logic [47:0]             pr1_r, pr2_r;
  logic signed [9:0]       pe1_r, pe2_r;
  logic [31:0]             p1_r, p2_r;
  logic [26:0]             big4_r, sml4_r;
  logic signed [9:0]       e4_r, e5_r, e6_r, e7_r;
  logic                    sg4_r, sub4_r, sg5_r, sg6_r, sg7_r, z7_r;
  spec_t                   sp4_r, sp5_r, sp6_r, sp7_r;
  logic [27:0]             sum5_r, sum6_r;
  logic [4:0]              lz6_r;
  logic [26:0]             sig7_r;
  logic [31:0]             res8_r;

  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_REG_BITS-1:0] v);
    logic [SIZE_BITS-1:0] t;
    t = SIZE_BITS'(v);
    return (t == '0) ? SIZE_BITS'(1) : t;
  endfunction

  function automatic logic signed [9:0] eff_exp(input logic [7:0] f);
    return (f == 8'd0) ? 10'sd1 : $signed({2'b00, f});
  endfunction

  assign adv   = !v_r[NST-1] || out_s.ready;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], !q_empty};
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_walk
    logic [LEVELS-1:0][SIZE_BITS-1:0] c_in;
    logic [3:0][OB-1:0]               o_in, k_in, o_nx, k_nx;
    logic [31:0]                      i_in;
    logic                             f_in;
    if (s == 0) begin : g_head
      assign c_in = h_cnt;
      assign i_in = h_index;
      assign f_in = h_final;
      for (genvar op = 0; op < 4; op++) begin : g_init
        assign o_in[op] = '0;
        assign k_in[op] = OB'(1);
      end
    end else begin : g_prev
      assign c_in = oc_r[s-1];
      assign i_in = ix_r[s-1];
      assign f_in = fn_r[s-1];
      assign o_in = off_r[s-1];
      assign k_in = scl_r[s-1];
    end
    if ((s < LEVELS) && (s < REG_LEVELS)) begin : g_lvl
      logic [SIZE_BITS-1:0] esz;
      assign esz = eff_size(cfg.sizes[s]);
      for (genvar op = 0; op < 4; op++) begin : g_op
        assign o_nx[op] = cfg.masks[4*s+op] ? o_in[op] + OB'(OB'(c_in[s]) * k_in[op]) : o_in[op];
        assign k_nx[op] = cfg.masks[4*s+op] ? OB'(k_in[op] * OB'(esz)) : k_in[op];
      end
    end else begin : g_pass
      assign o_nx = o_in;
      assign k_nx = k_in;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        oc_r[s]  <= c_in;
        ix_r[s]  <= i_in;
        fn_r[s]  <= f_in;
        off_r[s] <= o_nx;
        scl_r[s] <= k_nx;
      end
    end
  end

  // unpack and count leading zeros
  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r[0] <= h_item.a_value;
      x0_r[1] <= h_item.b_value;
      x0_r[2] <= h_item.c_value;
      x0_r[3] <= h_item.d_value;
      lz0_r[0] <= lzc27({mant24(h_item.a_value), 3'b111});
      lz0_r[1] <= lzc27({mant24(h_item.b_value), 3'b111});
      lz0_r[2] <= lzc27({mant24(h_item.c_value), 3'b111});
      lz0_r[3] <= lzc27({mant24(h_item.d_value), 3'b111});
      sp1_0_r <= mul_special(h_item.a_value, h_item.b_value);
      sp2_0_r <= mul_special(h_item.c_value, h_item.d_value);
    end
  end

  // normalize factors
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        m1_r[i] <= mant24(x0_r[i]) << lz0_r[i];
        e1_r[i] <= eff_exp(x0_r[i][30:23]) - $signed({5'd0, lz0_r[i]});
      end
      c1_r    <= x0_r[2];
      s1a_r   <= x0_r[0][31] ^ x0_r[1][31];
      s1b_r   <= x0_r[2][31] ^ x0_r[3][31];
      sp1_1_r <= sp1_0_r;
      sp2_1_r <= sp2_0_r;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (adv) begin
      pr1_r   <= m1_r[0] * m1_r[1];
      pr2_r   <= m1_r[2] * m1_r[3];
      pe1_r   <= $signed(e1_r[0]) + $signed(e1_r[1]) - 10'sd127;
      pe2_r   <= $signed(e1_r[2]) + $signed(e1_r[3]) - 10'sd127;
      c2_r    <= c1_r;
      s2a_r   <= s1a_r;
      s2b_r   <= s1b_r;
      sp1_2_r <= sp1_1_r;
      sp2_2_r <= sp2_1_r;
    end
  end

  // round products
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sp1_2_r.valid) p1_r <= sp1_2_r.bits;
      else if (pr1_r[47]) p1_r <= round_pack(s2a_r, pe1_r + 10'sd1, {pr1_r[47:22], |pr1_r[21:0]});
      else p1_r <= round_pack(s2a_r, pe1_r, {pr1_r[46:21], |pr1_r[20:0]});
      if (sp2_2_r.valid) p2_r <= sp2_2_r.bits;
      else if (pr2_r[47]) p2_r <= round_pack(s2b_r, pe2_r + 10'sd1, {pr2_r[47:22], |pr2_r[21:0]});
      else p2_r <= round_pack(s2b_r, pe2_r, {pr2_r[46:21], |pr2_r[20:0]});
      c3_r <= c2_r;
    end
  end

  // pick addend, catch specials, align
  logic [31:0] ax, ay, abig, asml;
  logic        xn, yn, xi, yi, xz, yz;
  spec_t       asp;
  logic [7:0]  diff;
  logic [26:0] bsig, ssig0, ssig;

  always_comb begin
    ax = (cfg.mode == MODE_RSUB) ? {~p1_r[31], p1_r[30:0]} : p1_r;
    case (cfg.mode)
      MODE_SUB:     ay = {~c3_r[31], c3_r[30:0]};
      MODE_DOT_ADD: ay = p2_r;
      MODE_DOT_SUB: ay = {~p2_r[31], p2_r[30:0]};
      default:      ay = c3_r;
    endcase
    xn = (ax[30:23] == 8'hFF) && (ax[22:0] != 23'd0);
    yn = (ay[30:23] == 8'hFF) && (ay[22:0] != 23'd0);
    xi = (ax[30:23] == 8'hFF) && (ax[22:0] == 23'd0);
    yi = (ay[30:23] == 8'hFF) && (ay[22:0] == 23'd0);
    xz = (ax[30:0] == 31'd0);
    yz = (ay[30:0] == 31'd0);
    asp = '{valid: 1'b1, bits: QNAN};
    if (xn || yn || (xi && yi && (ax[31] != ay[31]))) asp = '{valid: 1'b1, bits: QNAN};
    else if (xi) asp = '{valid: 1'b1, bits: ax};
    else if (yi) asp = '{valid: 1'b1, bits: ay};
    else if (xz && yz) asp = '{valid: 1'b1, bits: {ax[31] & ay[31], 31'd0}};
    else if (xz) asp = '{valid: 1'b1, bits: ay};
    else if (yz) asp = '{valid: 1'b1, bits: ax};
    else asp = '{valid: 1'b0, bits: 32'd0};
    if (ax[30:0] >= ay[30:0]) begin
      abig = ax;
      asml = ay;
    end else begin
      abig = ay;
      asml = ax;
    end
    diff  = 8'(eff_exp(abig[30:23]) - eff_exp(asml[30:23]));
    bsig  = {mant24(abig), 3'b000};
    ssig0 = {mant24(asml), 3'b000};
    if (diff >= 8'd27) ssig = {26'd0, |ssig0};
    else ssig = (ssig0 >> diff) | {26'd0, |(ssig0 & ((27'd1 << diff) - 27'd1))};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      big4_r <= bsig;
      sml4_r <= ssig;
      e4_r   <= eff_exp(abig[30:23]);
      sg4_r  <= abig[31];
      sub4_r <= abig[31] ^ asml[31];
      sp4_r  <= asp;
    end
  end

  // add or subtract magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      sum5_r <= sub4_r ? {1'b0, big4_r} - {1'b0, sml4_r} : {1'b0, big4_r} + {1'b0, sml4_r};
      e5_r   <= e4_r;
      sg5_r  <= sg4_r;
      sp5_r  <= sp4_r;
    end
  end

  // leading zero count of the sum
  always_ff @(posedge clk) begin
    if (adv) begin
      lz6_r  <= lzc27(sum5_r[26:0]);
      sum6_r <= sum5_r;
      e6_r   <= e5_r;
      sg6_r  <= sg5_r;
      sp6_r  <= sp5_r;
    end
  end

  // normalize
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sum6_r[27]) begin
        sig7_r <= {sum6_r[27:2], sum6_r[1] | sum6_r[0]};
        e7_r   <= e6_r + 10'sd1;
      end else begin
        sig7_r <= sum6_r[26:0] << lz6_r;
        e7_r   <= e6_r - $signed({5'd0, lz6_r});
      end
      z7_r  <= (sum6_r == 28'd0);
      sg7_r <= sg6_r;
      sp7_r <= sp6_r;
    end
  end

  // round and pack
  logic [31:0] fin_bits;
  always_comb begin
    if (sp7_r.valid) fin_bits = sp7_r.bits;
    else if (z7_r) fin_bits = 32'd0;
    else fin_bits = round_pack(sg7_r, e7_r, sig7_r);
    if ((fin_bits[30:23] == 8'hFF) && (fin_bits[22:0] != 23'd0)) fin_bits = QNAN;
  end

  always_ff @(posedge clk) begin
    if (adv) res8_r <= fin_bits;
  end

  assign out_s.valid = v_r[NST-1];
  assign out_s.data  = '{
    result_value:  res8_r,
    out_index:     ix_r[NST-1],
    next_a_offset: 32'(off_r[NST-1][0]),
    next_b_offset: 32'(off_r[NST-1][1]),
    next_c_offset: 32'(off_r[NST-1][2]),
    next_d_offset: 32'(off_r[NST-1][3]),
    final_element: fn_r[NST-1]
  };

endmodule

// ===== rtl/broadcast_walk_multiply_add.sv =====
// Throughput: one beat per cycle; a 4-entry queue separates the loop-nest front from
// the 9-stage float and offset pipeline, which advances whenever its output is free.
// Reset (synchronous, rst_n low): level counters and output index go to zero,
// sizes to one, masks and mode to zero; queue and pipeline empty.
module broadcast_walk_multiply_add #(
  parameter int LEVELS      = bwma_pkg::LEVELS_DEF,
  parameter int SIZE_BITS   = bwma_pkg::SIZE_BITS_DEF,
  parameter int OFFSET_BITS = bwma_pkg::OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = bwma_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bwma_cfg_if.sink     cfg_s,
  bwma_in_if.sink      in_s,
  bwma_out_if.source   out_s
);
  import bwma_pkg::*;

  localparam int QW = $bits(in_beat_t) + LEVELS * SIZE_BITS + 33;

  logic                             q_push, q_full, q_pop, q_empty, q_final, h_final;
  in_beat_t                         q_item, h_item;
  logic [LEVELS-1:0][SIZE_BITS-1:0] q_cnt, h_cnt;
  logic [31:0]                      q_index, h_index;
  logic [QW-1:0]                    q_wdata, q_rdata;
  cfg_t                             cfg;

  bwma_front #(.LEVELS(LEVELS), .SIZE_BITS(SIZE_BITS)) u_front (
    .clk, .rst_n, .cfg_s, .in_s,
    .q_full, .q_push, .q_item, .q_cnt, .q_index, .q_final,
    .cfg_o(cfg)
  );

  assign q_wdata = {q_item, q_cnt, q_index, q_final};

  bwma_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
  );

  assign {h_item, h_cnt, h_index, h_final} = q_rdata;

  bwma_back #(.LEVELS(LEVELS), .SIZE_BITS(SIZE_BITS), .OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk, .rst_n, .cfg, .q_empty, .q_pop,
    .h_item, .h_cnt, .h_index, .h_final, .out_s
  );

endmodule

// ===== tb/tb_broadcast_walk_multiply_add.sv =====
module tb_broadcast_walk_multiply_add;
  import bwma_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;

  logic clk;
  logic rst_n;

  bwma_cfg_if cfg_if ();
  bwma_in_if  in_if ();
  bwma_out_if out_if ();

  broadcast_walk_multiply_add dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_if),
    .in_s  (in_if),
    .out_s (out_if)
  );

  in_beat_t  operand_q[$];
  out_beat_t expected_q[$];

  logic [15:0] level_size[5];
  logic [19:0] advance_mask;
  logic [2:0]  mode_sel;
  logic [15:0] walk_count[5] = '{default: 16'd0};
  logic [31:0] walk_pos = '0;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_toggle;
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int cfg_writes;
  int finals_seen = 0;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- single-precision arithmetic ----------------
  function automatic void fp_split(input logic [31:0] x, output logic [23:0] m, output int e);
    if (x[30:23] == 8'd0) begin
      m = {1'b0, x[22:0]};
      e = -149;
    end else begin
      m = {1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] fp_round(input logic sgn, input logic [127:0] m, input int e);
    int          p;
    int          q;
    int          s;
    logic [127:0] mant;
    logic [127:0] rem;
    logic [127:0] half;
    p = -1;
    for (int i = 0; i < 128; i++) if (m[i]) p = i;
    if (p < 0) return {sgn, 31'd0};
    q = p + e - 23;
    if (q < -149) q = -149;
    s = q - e;
    if (s >= 128) return {sgn, 31'd0};
    if (s <= 0) begin
      mant = m << (-s);
    end else begin
      mant = m >> s;
      rem  = m & ((128'd1 << s) - 128'd1);
      half = 128'd1 << (s - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 128'd1;
    end
    if (mant[24]) begin
      mant = mant >> 1;
      q    = q + 1;
    end
    if (mant[23]) begin
      if (q + 150 >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, 8'(q + 150), mant[22:0]};
    end
    return {sgn, 8'd0, mant[22:0]};
  endfunction

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 23'd0;
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] == 23'd0;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
    logic [23:0] mx;
    logic [23:0] my;
    int          ex;
    int          ey;
    logic        zx;
    logic        zy;
    zx = x[30:0] == 31'd0;
    zy = y[30:0] == 31'd0;
    if (is_nan(x) || is_nan(y) || (is_inf(x) && zy) || (zx && is_inf(y))) return QNAN;
    if (is_inf(x) || is_inf(y)) return {x[31] ^ y[31], 8'hFF, 23'd0};
    if (zx || zy) return {x[31] ^ y[31], 31'd0};
    fp_split(x, mx, ex);
    fp_split(y, my, ey);
    return fp_round(x[31] ^ y[31], 128'(mx) * 128'(my), ex + ey);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
    logic [23:0]  mx;
    logic [23:0]  my;
    int           ex;
    int           ey;
    int           e;
    int           d;
    logic         sb;
    logic         ss;
    logic [127:0] big;
    logic [127:0] sm;
    if (is_nan(x) || is_nan(y)) return QNAN;
    if (is_inf(x) && is_inf(y) && x[31] != y[31]) return QNAN;
    if (is_inf(x)) return x;
    if (is_inf(y)) return y;
    if (x[30:0] == 31'd0 && y[30:0] == 31'd0) return {x[31] & y[31], 31'd0};
    if (x[30:0] == 31'd0) return y;
    if (y[30:0] == 31'd0) return x;
    fp_split(x, mx, ex);
    fp_split(y, my, ey);
    if (ex >= ey) begin
      sb = x[31];
      ss = y[31];
      d  = ex - ey;
      big = 128'(mx);
      sm  = 128'(my);
      e  = ey;
    end else begin
      sb = y[31];
      ss = x[31];
      d  = ey - ex;
      big = 128'(my);
      sm  = 128'(mx);
      e  = ex;
    end
    if (d <= 60) begin
      big = big << d;
    end else begin
      big = big << 30;
      sm  = 128'd1;
      e   = e + d - 30;
    end
    if (sb == ss) return fp_round(sb, big + sm, e);
    if (big == sm) return 32'd0;
    if (big > sm) return fp_round(sb, big - sm, e);
    return fp_round(ss, sm - big, e);
  endfunction

  function automatic logic [31:0] combine(input in_beat_t v, input logic [2:0] mode);
    logic [31:0] p1;
    logic [31:0] r;
    p1 = fp_mul(v.a_value, v.b_value);
    case (op_mode_e'(mode))
      MODE_SUB:     r = fp_add(p1, v.c_value ^ 32'h8000_0000);
      MODE_RSUB:    r = fp_add(v.c_value, p1 ^ 32'h8000_0000);
      MODE_DOT_ADD: r = fp_add(p1, fp_mul(v.c_value, v.d_value));
      MODE_DOT_SUB: r = fp_add(p1, fp_mul(v.c_value, v.d_value) ^ 32'h8000_0000);
      default:      r = fp_add(p1, v.c_value);
    endcase
    return is_nan(r) ? QNAN : r;
  endfunction

  // ---------------- loop-nest walk ----------------
  function automatic logic [31:0] eff_size(input int lvl);
    return level_size[lvl] == 16'd0 ? 32'd1 : 32'(level_size[lvl]);
  endfunction

  task automatic walk_and_predict(input in_beat_t v);
    out_beat_t   r;
    logic        carry;
    logic [31:0] off;
    logic [31:0] scale;
    r.result_value = combine(v, mode_sel);
    r.out_index    = walk_pos;
    carry = 1'b1;
    for (int l = 0; l < 5; l++) begin
      if (carry) begin
        if (32'(walk_count[l]) >= eff_size(l) - 32'd1) begin
          walk_count[l] = 16'd0;
        end else begin
          walk_count[l] = walk_count[l] + 16'd1;
          carry = 1'b0;
        end
      end
    end
    walk_pos = carry ? 32'd0 : walk_pos + 32'd1;
    for (int op = 0; op < 4; op++) begin
      off   = 32'd0;
      scale = 32'd1;
      for (int l = 0; l < 5; l++) begin
        if (advance_mask[4 * l + op]) begin
          off   = off + 32'(walk_count[l]) * scale;
          scale = scale * eff_size(l);
        end
      end
      case (op)
        0: r.next_a_offset = off;
        1: r.next_b_offset = off;
        2: r.next_c_offset = off;
        default: r.next_d_offset = off;
      endcase
    end
    r.final_element = carry;
    expected_q.push_back(r);
  endtask

  // ---------------- stimulus helpers ----------------
  function automatic logic [31:0] pick_operand();
    logic s;
    s = 1'($urandom);
    case ($urandom_range(9))
      4: begin
        case ($urandom_range(7))
          0: return 32'h0000_0000;
          1: return 32'h8000_0000;
          2: return 32'h7F80_0000;
          3: return 32'hFF80_0000;
          4: return {s, 8'hFF, 1'b1, 22'($urandom)};
          5: return {s, 8'hFF, 1'b0, 22'($urandom_range(1, 4194303))};
          6: return {s, 31'h7F7F_FFFF};
          default: return {s, 31'd1};
        endcase
      end
      5: return {s, 8'd0, 23'($urandom)};
      6: return {s, 8'($urandom_range(118, 136)), 23'($urandom)};
      7: return {s, 8'($urandom_range(230, 254)), 23'($urandom)};
      8: return {s, 8'($urandom_range(1, 24)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t v;
    v.a_value = pick_operand();
    v.b_value = pick_operand();
    v.c_value = pick_operand();
    v.d_value = pick_operand();
    if ($urandom_range(7) == 0) begin
      // near-cancellation: c close to a*b
      v.c_value = fp_mul(v.a_value, v.b_value) ^ 32'(($urandom_range(1) << 31) | $urandom_range(3));
    end
    return v;
  endfunction

  task automatic push_beat(input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d);
    operand_q.push_back('{a_value: a, b_value: b, c_value: c, d_value: d});
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [19:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: value};
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_MASKS: advance_mask = value;
      REG_MODE:  mode_sel = value[2:0];
      default:   level_size[int'(idx)] = value[15:0];
    endcase
    cfg_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (operand_q.size() != 0 || in_if.valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(11))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      3: return 16'($urandom);
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic configure(input logic [2:0] mode);
    for (int l = 0; l < 5; l++) write_reg(cfg_reg_e'(l), {4'($urandom), pick_size()});
    case ($urandom_range(3))
      0: write_reg(REG_MASKS, 20'hFFFFF);
      1: write_reg(REG_MASKS, 20'h00000);
      default: write_reg(REG_MASKS, 20'($urandom));
    endcase
    write_reg(REG_MODE, {17'd0, mode});
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else if (in_if.valid && !in_if.ready) begin
      in_if.valid <= 1'b1;
    end else begin
      if (in_if.valid) begin
        walk_and_predict(in_if.data);
        beats_in++;
      end
      if (operand_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.data  <= operand_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  int  hold_left;
  bit  hold_seen;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= hold_toggle;
    end else if (hold_toggle != hold_seen) begin
      hold_seen    <= hold_toggle;
      hold_left    <= 400;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // ---------------- monitor ----------------
  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("beat %0d: %s got %h want %h", beats_out, field, got, want);
  endtask

  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("beat %0d: result with nothing expected", beats_out);
      end else begin
        want = expected_q.pop_front();
        if (got.result_value != want.result_value)
          report("result_value", got.result_value, want.result_value);
        if (got.out_index != want.out_index) report("out_index", got.out_index, want.out_index);
        if (got.next_a_offset != want.next_a_offset)
          report("next_a_offset", got.next_a_offset, want.next_a_offset);
        if (got.next_b_offset != want.next_b_offset)
          report("next_b_offset", got.next_b_offset, want.next_b_offset);
        if (got.next_c_offset != want.next_c_offset)
          report("next_c_offset", got.next_c_offset, want.next_c_offset);
        if (got.next_d_offset != want.next_d_offset)
          report("next_d_offset", got.next_d_offset, want.next_d_offset);
        if (got.final_element != want.final_element)
          report("final_element", 32'(got.final_element), 32'(want.final_element));
        if (want.final_element) finals_seen++;
      end
      beats_out++;
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    for (int l = 0; l < 5; l++) begin
      level_size[l] = 16'd1;
    end
    advance_mask   = '0;
    mode_sel       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_toggle    = 1'b0;
    cfg_writes     = 0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    rst_n          = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats on the reset walk, then under a nest of sizes 2, 0, 3, 0xFFFF, 2 in DOT_SUB mode
    push_beat(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h0);
    push_beat(32'h7F80_0000, 32'h0000_0000, 32'h3F80_0000, 32'h0);
    push_beat(32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000, 32'h0);
    push_beat(32'h7FC0_0001, 32'h3F80_0000, 32'h0, 32'hFFFF_FFFF);
    push_beat(32'h8000_0000, 32'h3F80_0000, 32'h0000_0000, 32'h0);
    push_beat(32'h8000_0000, 32'h3F80_0000, 32'h8000_0000, 32'h0);
    push_beat(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0, 32'h0);
    push_beat(32'h0000_0001, 32'h3F00_0000, 32'h0, 32'h0);
    push_beat(32'h0080_0000, 32'h3F00_0000, 32'h0000_0001, 32'h0);
    push_beat(32'h3F80_0001, 32'h3F80_0001, 32'hBF80_0002, 32'h0);
    push_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
    write_reg(REG_SIZE0, 20'd2);
    write_reg(REG_SIZE1, 20'd0);
    write_reg(REG_SIZE2, 20'd3);
    write_reg(REG_SIZE3, 20'hFFFFF);
    write_reg(REG_SIZE4, 20'd2);
    write_reg(REG_MASKS, 20'hFFFFF);
    write_reg(REG_MODE, 20'(MODE_DOT_SUB));
    push_beat(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    push_beat(32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 32'h3FC0_0000);
    push_beat(32'h7F80_0000, 32'h3F80_0000, 32'h7F80_0000, 32'h3F80_0000);
    push_beat(32'h0, 32'h0, 32'h0, 32'h8000_0000);
    wait_drained();
    write_reg(REG_MODE, 20'($urandom_range(5, 7)));
    write_reg(REG_SIZE3, 20'd1);
    for (int i = 0; i < 6; i++) operand_q.push_back(random_beat());
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      configure(ph == 7 ? 3'($urandom_range(5, 7)) : 3'(ph % 5));
      if (ph == 0 || ph == 4) hold_toggle <= ~hold_toggle;
      for (int i = 0; i < 110; i++) operand_q.push_back(random_beat());
      // pause until everything has come back, then resume mid-walk
      while (operand_q.size() != 0 || in_if.valid || expected_q.size() != 0) @(posedge clk);
      for (int i = 0; i < 110; i++) operand_q.push_back(random_beat());
      wait_drained();
    end

    $display("%0d input beats and %0d result beats over %0d register writes,",
             beats_in, beats_out, cfg_writes);
    $display("%0d walks closed, all five modes and idle/stall mixes", finals_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
